FILE: hdl/tnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnp_pkg: shared types and constants of the token number parser
// Scan phases, radix codes, character codes and the digit decoder.
// ----------------------------------------------------------------------------
package tnp_pkg;

   // widths of the stream fields
   localparam int CHAR_BITS      = 8;
   localparam int VALUE_OUT_BITS = 32;
   localparam int RADIX_BITS     = 2;
   localparam int DIGIT_BITS     = 4;
   localparam int RSP_USER_BITS  = 2 + RADIX_BITS;

   // bit positions inside rsp_tuser
   localparam int USER_PRESENT = 0;
   localparam int USER_VALID   = 1;
   localparam int USER_RADIX_LO = 2;

   // scan phase, one-hot
   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_ZERO  = 4'b0010,
      PH_HASH  = 4'b0100,
      PH_DIGIT = 4'b1000
   } phase_type;

   // radix codes as reported on the result channel
   typedef enum logic [RADIX_BITS-1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2
   } radix_type;

   // character codes
   localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_HASH  = 8'h23;
   localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_UC_A  = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UC_F  = 8'h46;
   localparam logic [CHAR_BITS-1:0] CH_UC_O  = 8'h4F;
   localparam logic [CHAR_BITS-1:0] CH_UC_X  = 8'h58;
   localparam logic [CHAR_BITS-1:0] CH_LC_A  = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_LC_F  = 8'h66;
   localparam logic [CHAR_BITS-1:0] CH_LC_O  = 8'h6F;
   localparam logic [CHAR_BITS-1:0] CH_LC_X  = 8'h78;

   // digit decode result
   typedef struct packed {
      logic                  ok;
      logic [DIGIT_BITS-1:0] val;
   } digit_type;

   // map a character to its digit value, ok low when it is no digit at all
   function automatic digit_type digit_decode(logic [CHAR_BITS-1:0] c);
      digit_type d;
      d.ok  = 1'b1;
      d.val = '0;
      if (c >= CH_LC_A && c <= CH_LC_F) begin
         d.val = DIGIT_BITS'(c - CH_LC_A + 8'd10);
      end else if (c >= CH_UC_A && c <= CH_UC_F) begin
         d.val = DIGIT_BITS'(c - CH_UC_A + 8'd10);
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
         d.val = DIGIT_BITS'(c - CH_ZERO);
      end else begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

   // digit value below the base of the radix
   function automatic logic digit_in_base(logic [DIGIT_BITS-1:0] v, radix_type r);
      logic res;
      case (r)
         RADIX_HEX: res = 1'b1;
         RADIX_OCT: res = (v < 4'd8);
         default:   res = (v < 4'd10);
      endcase
      return res;
   endfunction

endpackage

FILE: hdl/token_number_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_number_parser_top: command line integer token parser
// Parses whitespace separated tokens of a byte stream as decimal, octal or
// hexadecimal integers and gives one result word per token and per empty line end.
// ----------------------------------------------------------------------------
// Usage
//   req_ channel: one character word per transfer (req_tdata). Byte 0 ends
//   the line, bytes up to space and bytes 128 to 255 separate tokens.
//   rsp_ channel: one word when a token ends and one at a line end with no token;
//   rsp_tdata holds the value, rsp_tuser the flags, rsp_tlast the line end.
//   Path: a character passes the input register, then the result register,
//   on its way to its result word.
//   Throughput: one character per cycle while the result register has room;
//   the scan state and one shift-add of the accumulator sit between the
//   input and the result register. A separator between tokens gives no word.
//   Stall: while a result word waits on rsp_tready, a character is still
//   taken when the input register is empty or holds a character with no word;
//   the scan state only advances when that character can hand its result on.
//   Reset: synchronous, clears the valid bits of both registers and sets the
//   scan state to between tokens, decimal, accumulator zero.
// ----------------------------------------------------------------------------
module token_number_parser_top #(
   parameter int VALUE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // character words
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tnp_pkg::CHAR_BITS-1:0]        req_tdata,  // char_code[7:0]
   // result words
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tnp_pkg::VALUE_OUT_BITS-1:0]   rsp_tdata,  // number_value[31:0]
   // token_present[0], number_valid[1], radix_code[3:2]
   output logic [tnp_pkg::RSP_USER_BITS-1:0]    rsp_tuser,
   output logic                                 rsp_tlast   // line_end
);
   import tnp_pkg::*;

   // input register
   logic                      in_valid_ff;
   logic [CHAR_BITS-1:0]      in_char_ff;

   // scan state
   phase_type                 phase_ff, phase_in;
   radix_type                 radix_ff, radix_in;
   logic [VALUE_BITS-1:0]     acc_ff, acc_in;
   logic                      bad_ff, bad_in;

   // result register
   logic                      rsp_valid_ff;
   logic [VALUE_OUT_BITS-1:0] rsp_value_ff;
   logic                      rsp_present_ff;
   logic                      rsp_good_ff;
   radix_type                 rsp_radix_ff;
   logic                      rsp_last_ff;

   // combinational results of the current character
   logic                      has_res;
   logic                      res_present;
   logic [VALUE_OUT_BITS-1:0] res_value;
   logic                      res_good;
   radix_type                 res_radix;
   logic                      res_last;

   logic                      is_sep;
   logic                      is_eol;
   logic                      take_digit;
   radix_type                 dig_radix;
   digit_type                 dig;
   logic                      tok_bad;
   logic [VALUE_BITS-1:0]     acc_scaled;
   logic [VALUE_OUT_BITS-1:0] acc_low;

   logic                      out_room;
   logic                      s1_fire;

   // handshake between the two registers
   assign out_room   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = in_valid_ff && (!has_res || out_room);
   assign req_tready = !in_valid_ff || s1_fire;

   // character classes
   assign is_sep  = (in_char_ff <= CH_SPACE) || in_char_ff[CHAR_BITS-1];
   assign is_eol  = (in_char_ff == CH_NUL);
   assign dig     = digit_decode(in_char_ff);
   assign acc_low = VALUE_OUT_BITS'(acc_ff);

   // scan step for one character
   always_comb begin
      phase_in    = phase_ff;
      radix_in    = radix_ff;
      acc_in      = acc_ff;
      bad_in      = bad_ff;
      has_res     = 1'b0;
      res_present = 1'b0;
      res_value   = '0;
      res_good    = 1'b0;
      res_radix   = RADIX_DEC;
      res_last    = 1'b0;
      take_digit  = 1'b0;
      dig_radix   = radix_ff;
      tok_bad     = 1'b0;
      acc_scaled  = '0;

      if (is_sep) begin
         // token end or line end, state returns to between tokens
         if (phase_ff == PH_IDLE) begin
            has_res  = is_eol;
            res_last = 1'b1;
         end else begin
            tok_bad     = bad_ff || (phase_ff == PH_HASH);
            has_res     = 1'b1;
            res_present = 1'b1;
            res_value   = tok_bad ? '0 : acc_low;
            res_good    = !tok_bad;
            res_radix   = (phase_ff == PH_ZERO) ? RADIX_OCT : radix_ff;
            res_last    = is_eol;
         end
         phase_in = PH_IDLE;
         radix_in = RADIX_DEC;
         acc_in   = '0;
         bad_in   = 1'b0;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (in_char_ff == CH_ZERO) begin
                  phase_in = PH_ZERO;
               end else if (in_char_ff == CH_HASH) begin
                  phase_in = PH_HASH;
               end else begin
                  phase_in   = PH_DIGIT;
                  radix_in   = RADIX_DEC;
                  take_digit = 1'b1;
                  dig_radix  = RADIX_DEC;
               end
            end
            PH_ZERO: begin
               phase_in = PH_DIGIT;
               if (in_char_ff == CH_LC_X) begin
                  radix_in = RADIX_HEX;
               end else begin
                  radix_in   = RADIX_OCT;
                  take_digit = 1'b1;
                  dig_radix  = RADIX_OCT;
               end
            end
            PH_HASH: begin
               phase_in = PH_DIGIT;
               if (in_char_ff == CH_LC_X || in_char_ff == CH_UC_X) begin
                  radix_in = RADIX_HEX;
               end else if (in_char_ff == CH_LC_O || in_char_ff == CH_UC_O) begin
                  radix_in = RADIX_OCT;
               end else begin
                  bad_in = 1'b1;
               end
            end
            PH_DIGIT: begin
               take_digit = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         // one shift-add of the accumulator, ignored once the token is bad
         case (dig_radix)
            RADIX_HEX: acc_scaled = acc_ff << 4;
            RADIX_OCT: acc_scaled = acc_ff << 3;
            default:   acc_scaled = (acc_ff << 3) + (acc_ff << 1);
         endcase
         if (take_digit && !bad_ff) begin
            if (dig.ok && digit_in_base(dig.val, dig_radix)) begin
               acc_in = acc_scaled + VALUE_BITS'(dig.val);
            end else begin
               bad_in = 1'b1;
            end
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         radix_ff <= RADIX_DEC;
         acc_ff   <= '0;
         bad_ff   <= 1'b0;
      end else if (s1_fire) begin
         phase_ff <= phase_in;
         radix_ff <= radix_in;
         acc_ff   <= acc_in;
         bad_ff   <= bad_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (s1_fire && has_res) || (rsp_valid_ff && !rsp_tready);
      end
      if (s1_fire && has_res) begin
         rsp_value_ff   <= res_value;
         rsp_present_ff <= res_present;
         rsp_good_ff    <= res_good;
         rsp_radix_ff   <= res_radix;
         rsp_last_ff    <= res_last;
      end
   end

   // result word
   assign rsp_tvalid                                   = rsp_valid_ff;
   assign rsp_tdata                                    = rsp_value_ff;
   assign rsp_tuser[USER_PRESENT]                      = rsp_present_ff;
   assign rsp_tuser[USER_VALID]                        = rsp_good_ff;
   assign rsp_tuser[USER_RADIX_LO +: RADIX_BITS]       = rsp_radix_ff;
   assign rsp_tlast                                    = rsp_last_ff;

`ifndef ASSERT_OFF
   // a word without a token is only the empty line end
   a_empty_eol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_present_ff |-> rsp_last_ff && !rsp_good_ff
         && rsp_value_ff == '0 && rsp_radix_ff == RADIX_DEC)
      else $error("empty result word is not a clean line end");

   // an invalid token reports value zero
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_good_ff |-> rsp_value_ff == '0)
      else $error("invalid token with nonzero value");

   // any separator leaves the scan state between tokens
   a_sep_clears: assert property (@(posedge clock) disable iff (reset)
      s1_fire && is_sep |=> phase_ff == PH_IDLE && acc_ff == '0 && !bad_ff
         && radix_ff == RADIX_DEC)
      else $error("scan state not cleared after separator");

   // the scan state holds while the character waits on a full result register
   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !s1_fire |=> $stable(phase_ff) && $stable(acc_ff))
      else $error("scan state moved on a stalled character");

   // radix code is never the unused code
   a_radix_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_radix_ff == RADIX_DEC || rsp_radix_ff == RADIX_OCT
         || rsp_radix_ff == RADIX_HEX)
      else $error("unused radix code on result word");
`endif

endmodule

FILE: sim/token_number_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_number_parser_top_tb: self-checking bench of the token number parser
// Streams command lines into the character channel and checks every result
// word against a cycle-free model of the parser. A short directed part
// covers prefixes, wrap-around, bad digits and separators. The random part
// is mostly well-formed lines with some noise. Both channels idle at random,
// the receiver stalls long once and the sender drains now and then.
// ----------------------------------------------------------------------------
module token_number_parser_top_tb;
   import tnp_pkg::*;

   // expected result word
   typedef struct {
      logic                      present;
      logic [VALUE_OUT_BITS-1:0] value;
      logic                      valid;
      radix_type                 radix;
      logic                      line_end;
   } result_word_type;

   // pending character word with its flow controls
   typedef struct {
      logic [CHAR_BITS-1:0] code;
      bit                   drain;   // wait until no result is outstanding
      bit                   hold;    // ask the receiver for a long stall
   } char_item_type;

   localparam int RANDOM_CHARS = 1000;
   localparam int LONG_HOLD    = 150;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [CHAR_BITS-1:0]      req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [VALUE_OUT_BITS-1:0] rsp_tdata;
   logic [RSP_USER_BITS-1:0]  rsp_tuser;
   logic                      rsp_tlast;

   char_item_type   char_queue[$];
   result_word_type expected_words[$];
   int              error_count = 0;
   int              hold_kicks  = 0;

   // parser model state
   phase_type                 scan_ph;
   radix_type                 radix_now;
   logic [VALUE_OUT_BITS-1:0] acc_now;
   logic                      bad_now;

   token_number_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   // ---------------------------------------------------------------- model
   task automatic clear_token();
      scan_ph   = PH_IDLE;
      radix_now = RADIX_DEC;
      acc_now   = '0;
      bad_now   = 1'b0;
   endtask

   function automatic logic [VALUE_OUT_BITS-1:0] radix_base(input radix_type r);
      if (r == RADIX_HEX) return 16;
      if (r == RADIX_OCT) return 8;
      return 10;
   endfunction

   // one digit into the accumulator, any error sticks until the token ends
   task automatic take_digit(input logic [CHAR_BITS-1:0] c);
      logic [VALUE_OUT_BITS-1:0] d;
      logic [VALUE_OUT_BITS-1:0] b;
      if (bad_now) return;
      b = radix_base(radix_now);
      if (c >= CH_LC_A && c <= CH_LC_F) d = c - CH_LC_A + 10;
      else if (c >= CH_UC_A && c <= CH_UC_F) d = c - CH_UC_A + 10;
      else if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO;
      else begin
         bad_now = 1'b1;
         return;
      end
      if (d >= b) bad_now = 1'b1;
      else acc_now = acc_now * b + d;
   endtask

   // advance the model by one accepted character
   task automatic parse_char(input logic [CHAR_BITS-1:0] c);
      result_word_type w;
      if (c <= CH_SPACE || c[CHAR_BITS-1]) begin
         if (scan_ph == PH_IDLE) begin
            if (c == CH_NUL) begin
               w.present  = 1'b0;
               w.value    = '0;
               w.valid    = 1'b0;
               w.radix    = RADIX_DEC;
               w.line_end = 1'b1;
               expected_words.push_back(w);
               clear_token();
            end
            return;
         end
         if (scan_ph == PH_ZERO) radix_now = RADIX_OCT;
         if (scan_ph == PH_HASH) bad_now = 1'b1;
         w.present  = 1'b1;
         w.value    = bad_now ? '0 : acc_now;
         w.valid    = !bad_now;
         w.radix    = radix_now;
         w.line_end = (c == CH_NUL);
         expected_words.push_back(w);
         clear_token();
         return;
      end
      case (scan_ph)
         PH_IDLE: begin
            if (c == CH_ZERO) scan_ph = PH_ZERO;
            else if (c == CH_HASH) scan_ph = PH_HASH;
            else begin
               radix_now = RADIX_DEC;
               scan_ph   = PH_DIGIT;
               take_digit(c);
            end
         end
         PH_ZERO: begin
            scan_ph = PH_DIGIT;
            if (c == CH_LC_X) radix_now = RADIX_HEX;
            else begin
               radix_now = RADIX_OCT;
               take_digit(c);
            end
         end
         PH_HASH: begin
            scan_ph = PH_DIGIT;
            if (c == CH_LC_X || c == CH_UC_X) radix_now = RADIX_HEX;
            else if (c == CH_LC_O || c == CH_UC_O) radix_now = RADIX_OCT;
            else bad_now = 1'b1;
         end
         default: begin
            take_digit(c);
         end
      endcase
   endtask

   // ------------------------------------------------------------ stimulus
   task automatic push_char(input logic [CHAR_BITS-1:0] c, input bit drain = 0,
                            input bit hold = 0);
      char_item_type it;
      it.code  = c;
      it.drain = drain;
      it.hold  = hold;
      char_queue.push_back(it);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endtask

   // separator: mostly space, sometimes control or high bytes
   function automatic logic [CHAR_BITS-1:0] rand_sep();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return CH_SPACE;
      if (r < 7) return CHAR_BITS'($urandom_range(1, 32));
      return CHAR_BITS'($urandom_range(128, 255));
   endfunction

   // digit valid for the base, with the odd corrupted character
   task automatic push_digit(input int base);
      int v;
      v = $urandom_range(0, base - 1);
      if ($urandom_range(0, 29) == 0) push_char(CHAR_BITS'($urandom_range(33, 126)));
      else if (v < 10) push_char(CH_ZERO + CHAR_BITS'(v));
      else if ($urandom_range(0, 1)) push_char(CH_LC_A + CHAR_BITS'(v - 10));
      else push_char(CH_UC_A + CHAR_BITS'(v - 10));
   endtask

   task automatic push_digits(input int base, input int count);
      for (int i = 0; i < count; i++) push_digit(base);
   endtask

   // one random token of a chosen kind
   task automatic push_token();
      int kind;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: begin
            push_char(CHAR_BITS'($urandom_range(CH_ZERO + 1, CH_NINE)));
            push_digits(10, $urandom_range(0, 11));
         end
         3: begin
            push_char(CH_ZERO);
            push_digits(8, $urandom_range(0, 12));
         end
         4, 5: begin
            push_char(CH_ZERO);
            push_char(CH_LC_X);
            push_digits(16, $urandom_range(0, 10));
         end
         6: begin
            push_char(CH_HASH);
            case ($urandom_range(0, 3))
               0: begin push_char(CH_LC_X); push_digits(16, $urandom_range(0, 9)); end
               1: begin push_char(CH_UC_X); push_digits(16, $urandom_range(0, 9)); end
               2: begin push_char(CH_LC_O); push_digits(8, $urandom_range(0, 11)); end
               default: begin push_char(CH_UC_O); push_digits(8, $urandom_range(0, 11)); end
            endcase
         end
         7: begin
            if ($urandom_range(0, 1)) begin
               push_char(CH_HASH);
               push_char(CHAR_BITS'($urandom_range(33, 126)));
            end else begin
               push_char(CH_ZERO);
               push_char(CH_UC_X);
            end
            push_digits(16, $urandom_range(0, 4));
         end
         8: begin
            push_char($urandom_range(0, 1) ? CH_ZERO : CH_HASH);
         end
         default: begin
            for (int i = $urandom_range(1, 5); i > 0; i--)
               push_char(CHAR_BITS'($urandom_range(33, 127)));
         end
      endcase
   endtask

   // a command line: random tokens between separators, closed by nul
   task automatic push_line();
      int ntok;
      ntok = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) push_char(rand_sep());
      for (int t = 0; t < ntok; t++) begin
         push_token();
         if (t < ntok - 1 || $urandom_range(0, 1))
            for (int s = $urandom_range(1, 3); s > 0; s--) push_char(rand_sep());
      end
      if ($urandom_range(0, 7) == 0) push_char(CHAR_BITS'($urandom_range(0, 255)));
      push_char(CH_NUL);
   endtask

   // gap length: mostly none or short, a few long, sometimes a busy burst
   function automatic int pick_gap(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         burst = $urandom_range(30, 80);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // -------------------------------------------------------------- driver
   int send_gap   = 0;
   int send_burst = 0;
   always @(posedge clock) begin
      bit            offering;
      char_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   = 0;
      end else begin
         offering = req_tvalid;
         if (req_tvalid && req_tready) begin
            parse_char(req_tdata);
            offering = 1'b0;
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (char_queue.size() > 0 &&
                         !(char_queue[0].drain && expected_words.size() != 0)) begin
               it = char_queue.pop_front();
               req_tdata <= it.code;
               offering = 1'b1;
               if (it.hold) hold_kicks <= hold_kicks + 1;
               send_gap = pick_gap(send_burst);
            end
         end
         req_tvalid <= offering;
      end
   end

   // ------------------------------------------------------ receiver ready
   int hold_seen  = 0;
   int hold_left  = 0;
   int recv_gap   = 0;
   int recv_burst = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  = 0;
         recv_gap   = 0;
      end else begin
         if (hold_kicks != hold_seen) begin
            hold_seen = hold_kicks;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap = pick_gap(recv_burst);
         end
      end
   end

   // ------------------------------------------------------------- monitor
   always @(posedge clock) begin
      result_word_type got;
      result_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.present  = rsp_tuser[USER_PRESENT];
         got.valid    = rsp_tuser[USER_VALID];
         got.radix    = radix_type'(rsp_tuser[USER_RADIX_LO +: RADIX_BITS]);
         got.value    = rsp_tdata;
         got.line_end = rsp_tlast;
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word value %h user %b last %b",
                                      rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            want = expected_words.pop_front();
            if (got.present !== want.present)
               report_mismatch($sformatf("token_present %b, expected %b",
                                         got.present, want.present));
            if (got.value !== want.value)
               report_mismatch($sformatf("number_value %h, expected %h",
                                         got.value, want.value));
            if (got.valid !== want.valid)
               report_mismatch($sformatf("number_valid %b, expected %b",
                                         got.valid, want.valid));
            if (got.radix !== want.radix)
               report_mismatch($sformatf("radix_code %0d, expected %0d",
                                         got.radix, want.radix));
            if (got.line_end !== want.line_end)
               report_mismatch($sformatf("line_end %b, expected %b",
                                         got.line_end, want.line_end));
         end
      end
   end

   // ---------------------------------------------------------------- main
   initial begin
      int base_count;
      int tail_wait;
      bit hold_planted;
      clear_token();
      hold_planted = 1'b0;

      // directed: empty line, every prefix, bad prefixes, wrap, separators
      push_char(CH_NUL);
      push_text(" 0 0x #x #o #Xf #O7 # #z1 0X1 019 9z9");
      push_char(8'h80);
      push_text("4294967296");
      push_char(8'hFF);
      push_text("0xFFFFFFFF");
      push_char(8'h01);
      push_text("12");
      push_char(CH_NUL);

      // sender waits here until every directed result is back
      push_char(CH_SPACE, 1'b1, 1'b0);

      // random lines, draining now and then, one long receiver stall
      base_count = char_queue.size();
      while (char_queue.size() - base_count < RANDOM_CHARS) begin
         if ((char_queue.size() - base_count) % 200 < 12 && $urandom_range(0, 1))
            push_char(rand_sep(), 1'b1, 1'b0);
         if (!hold_planted && char_queue.size() - base_count > 300) begin
            push_char(CH_SPACE, 1'b0, 1'b1);
            hold_planted = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) push_char(CHAR_BITS'($urandom_range(0, 255)));
         else push_line();
      end
      push_char(CH_NUL);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // all words sent, then all results back, then a settling wait
      while (char_queue.size() != 0 || req_tvalid) @(posedge clock);
      tail_wait = 0;
      while (expected_words.size() != 0 && tail_wait < 5000) begin
         @(posedge clock);
         tail_wait++;
      end
      repeat (10) @(posedge clock);
      if (expected_words.size() != 0)
         report_mismatch($sformatf("%0d result words never arrived",
                                   expected_words.size()));

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: token_number_parser_top.f
hdl/tnp_pkg.sv
hdl/token_number_parser_top.sv
sim/token_number_parser_top_tb.sv
